### rtl/fds_pkg.sv
package fds_pkg;

  // decimal scale of all rate work
  localparam logic [19:0] SCALE = 20'd1000000;
  // floor(x / SCALE) = (x * SCALE_RECIP) >> RECIP_SHIFT for x below 2^29
  localparam logic [29:0] SCALE_RECIP = 30'd562949954;
  localparam int unsigned RECIP_SHIFT = 49;
  // frac * SCALE / 255 = frac * FRAC_WHOLE + floor(frac * FRAC_PART / 255)
  localparam logic [11:0] FRAC_WHOLE = 12'd3921;
  localparam logic [7:0]  FRAC_PART  = 8'd145;
  localparam logic [7:0]  FRAC_MAX   = 8'hff;
  localparam logic [7:0]  FILL_BITS  = 8'hff;
  localparam logic [31:0] PARENT_RESET = 32'd24576000;
  localparam int unsigned SEL_SHIFT   = 24;
  localparam int unsigned INTEG_SHIFT = 16;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_HIGH = 2'd1,
    ST_ZERO = 2'd2,
    ST_SAT  = 2'd3
  } status_e;

  typedef enum logic {
    CMD_BUILD = 1'b0,
    CMD_EVAL  = 1'b1
  } command_e;

  typedef struct packed {
    logic        command;
    logic [31:0] target_rate;
    logic [31:0] reg_value;
  } in_t;

  typedef struct packed {
    logic [31:0] reg_word;
    logic [31:0] rate_out;
    logic [1:0]  status;
  } out_t;

endpackage

### rtl/fds_divider.sv
module fds_divider #(
  parameter int unsigned DW = 52,
  parameter int unsigned VW = 32,
  parameter int unsigned TW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [DW-1:0] dvd_i,
  input  logic [VW-1:0] dvs_i,
  input  logic [TW-1:0] tag_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [DW-1:0] quo_o,
  output logic [VW-1:0] rem_o,
  output logic [TW-1:0] tag_o
);

  // stage 0 holds the captured beat, stage k has k quotient bits done
  logic [DW:0]   vld_q;
  logic [VW-1:0] rem_q [DW+1];
  logic [VW-1:0] rem_d [DW+1];
  logic [DW-1:0] dvd_q [DW+1];
  logic [DW-1:0] dvd_d [DW+1];
  logic [DW-1:0] quo_q [DW+1];
  logic [DW-1:0] quo_d [DW+1];
  logic [VW-1:0] dvs_q [DW+1];
  logic [VW-1:0] dvs_d [DW+1];
  logic [TW-1:0] tag_q [DW+1];
  logic [TW-1:0] tag_d [DW+1];
  logic [VW:0]   trial [DW+1];
  logic          en;

  // whole pipe moves unless the last beat is stalled
  assign en = !vld_q[DW] || out_ready_i;
  assign in_ready_o = en;

  // one restoring step per stage
  always_comb begin
    rem_d[0] = '0;
    dvd_d[0] = dvd_i;
    quo_d[0] = '0;
    dvs_d[0] = dvs_i;
    tag_d[0] = tag_i;
    trial[0] = '0;
    for (int k = 1; k <= DW; k++) begin
      trial[k] = {rem_q[k-1], dvd_q[k-1][DW-1]} - {1'b0, dvs_q[k-1]};
      if (!trial[k][VW]) begin
        rem_d[k] = trial[k][VW-1:0];
      end else begin
        rem_d[k] = {rem_q[k-1][VW-2:0], dvd_q[k-1][DW-1]};
      end
      dvd_d[k] = {dvd_q[k-1][DW-2:0], 1'b0};
      quo_d[k] = {quo_q[k-1][DW-2:0], !trial[k][VW]};
      dvs_d[k] = dvs_q[k-1];
      tag_d[k] = tag_q[k-1];
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[DW-1:0], in_valid_i};
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k <= DW; k++) begin
        rem_q[k] <= rem_d[k];
        dvd_q[k] <= dvd_d[k];
        quo_q[k] <= quo_d[k];
        dvs_q[k] <= dvs_d[k];
        tag_q[k] <= tag_d[k];
      end
    end
  end

  assign out_valid_o = vld_q[DW];
  assign quo_o = quo_q[DW];
  assign rem_o = rem_q[DW];
  assign tag_o = tag_q[DW];

endmodule

### rtl/fractional_divider_setting.sv
// Fractional divider setting calculator. A beat with command 0 turns a target
// rate into a divider register word and the rate that word really yields; a
// beat with command 1 gives the rate of a register word. Beats are accepted
// one per cycle while the output is not stalled and leave in order, through
// two one-bit-per-stage restoring dividers for the scaled quotient
// parent*1e6/target and the final parent*1e6/divisor; the split into whole
// and remainder and the 0..255 fraction use four stages of reciprocal
// multiplication. The user must write the parent clock rate through
// cfg_we_i/cfg_data_i while no beat is in flight; the block does not enforce it.
module fractional_divider_setting #(
  parameter int unsigned RATE_BITS = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [31:0]     cfg_data_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  fds_pkg::in_t    in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output fds_pkg::out_t   out_data_o
);

  localparam int unsigned RB = RATE_BITS;
  localparam int unsigned NW = RB + 20;   // parent * 1e6
  localparam int unsigned QW = 29;        // useful scaled quotient, below 512e6
  localparam int unsigned FW = 28;        // remainder * 255
  localparam int unsigned DV = 29;        // divisor of the final division
  localparam int unsigned PW = QW + 30;   // scaled quotient times reciprocal
  localparam int unsigned XW = FW + 30;   // remainder * 255 times reciprocal

  typedef struct packed {
    logic          cmd;
    logic [1:0]    st;
    logic          sel;
    logic [7:0]    integ;
    logic [7:0]    frac;
    logic [NW-1:0] n;
  } tag_t;

  typedef struct packed {
    logic        cmd;
    logic [1:0]  st;
    logic        zero;
    logic [31:0] word;
  } tag2_t;

  localparam int unsigned TW  = $bits(tag_t);
  localparam int unsigned TW2 = $bits(tag2_t);

  logic [31:0] parent_q;

  // parent rate register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parent_q <= fds_pkg::PARENT_RESET;
    end else if (cfg_we_i) begin
      parent_q <= cfg_data_i;
    end
  end

  // ---------------- input stage ----------------
  logic          s0_vld_q;
  tag_t          s0_tag_q, s0_tag_d;
  logic [RB-1:0] s0_tgt_q;
  logic          en0;
  logic          d1_ready;
  logic [RB-1:0] tgt, par;

  assign en0 = !s0_vld_q || d1_ready;
  assign in_ready_o = en0;
  assign tgt = in_data_i.target_rate[RB-1:0];
  assign par = parent_q[RB-1:0];

  // early checks and register fields
  always_comb begin
    s0_tag_d.cmd   = in_data_i.command;
    s0_tag_d.sel   = in_data_i.reg_value[fds_pkg::SEL_SHIFT];
    s0_tag_d.integ = in_data_i.reg_value[fds_pkg::INTEG_SHIFT +: 8];
    s0_tag_d.frac  = in_data_i.reg_value[7:0];
    s0_tag_d.n     = NW'(par) * NW'(fds_pkg::SCALE);
    s0_tag_d.st    = fds_pkg::ST_OK;
    if (in_data_i.command == fds_pkg::CMD_BUILD) begin
      if (tgt == '0) begin
        s0_tag_d.st = fds_pkg::ST_ZERO;
      end else if ({tgt, 1'b0} > {1'b0, par}) begin
        s0_tag_d.st = fds_pkg::ST_HIGH;
      end else if ({9'd0, par} >= {tgt, 9'd0}) begin
        s0_tag_d.st = fds_pkg::ST_SAT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else if (en0) begin
      s0_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en0) begin
      s0_tag_q <= s0_tag_d;
      s0_tgt_q <= tgt;
    end
  end

  // ---------------- scaled quotient parent*1e6/target ----------------
  logic          d1_vld, d2_ready;
  logic [NW-1:0] d1_quo;
  logic [RB-1:0] d1_rem;
  logic [TW-1:0] d1_tag;

  fds_divider #(.DW(NW), .VW(RB), .TW(TW)) u_div_quo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s0_vld_q),
    .in_ready_o (d1_ready),
    .dvd_i      (s0_tag_q.n),
    .dvs_i      (s0_tgt_q),
    .tag_i      (TW'(s0_tag_q)),
    .out_valid_o(d1_vld),
    .out_ready_i(d2_ready),
    .quo_o      (d1_quo),
    .rem_o      (d1_rem),
    .tag_o      (d1_tag)
  );

  // ---------------- whole, remainder and fraction by reciprocal ----------------
  logic          en1, enc;
  logic          c1_vld_q, c2_vld_q, c3_vld_q, c4_vld_q;
  logic [QW-1:0] c1_q_q;
  logic [PW-1:0] c1_p_q;
  logic [TW-1:0] c1_tag_q;
  logic [9:0]    whole;
  logic [19:0]   c2_rem_q, c2_rem_d;
  tag_t          t2, t3m, c2_tag_q, c3_tag_q, c4_tag_q;
  logic [FW-1:0] c3_x_q;
  logic [XW-1:0] c4_p_q;

  // the four stages move together unless the last one is stalled
  assign enc = !c4_vld_q || en1;
  assign d2_ready = enc;
  assign t2 = tag_t'(c1_tag_q);
  assign whole = c1_p_q[PW-1:fds_pkg::RECIP_SHIFT];
  assign c2_rem_d = 20'(c1_q_q - (QW'(whole) * QW'(fds_pkg::SCALE)));

  // merge whole into sel and integ, saturate the divider
  always_comb begin
    t3m = t2;
    if (t2.cmd == fds_pkg::CMD_BUILD) begin
      if (t2.st == fds_pkg::ST_SAT) begin
        t3m.sel   = 1'b1;
        t3m.integ = fds_pkg::FRAC_MAX;
        t3m.frac  = fds_pkg::FRAC_MAX;
      end else begin
        t3m.sel   = whole[0];
        t3m.integ = whole[8:1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_vld_q <= 1'b0;
      c2_vld_q <= 1'b0;
      c3_vld_q <= 1'b0;
      c4_vld_q <= 1'b0;
    end else if (enc) begin
      c1_vld_q <= d1_vld;
      c2_vld_q <= c1_vld_q;
      c3_vld_q <= c2_vld_q;
      c4_vld_q <= c3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (enc) begin
      c1_q_q   <= d1_quo[QW-1:0];
      c1_p_q   <= PW'(d1_quo[QW-1:0]) * PW'(fds_pkg::SCALE_RECIP);
      c1_tag_q <= d1_tag;
      c2_rem_q <= c2_rem_d;
      c2_tag_q <= t3m;
      c3_x_q   <= {c2_rem_q, 8'd0} - FW'(c2_rem_q);
      c3_tag_q <= c2_tag_q;
      c4_p_q   <= XW'(c3_x_q) * XW'(fds_pkg::SCALE_RECIP);
      c4_tag_q <= c3_tag_q;
    end
  end

  // ---------------- word build and divisor products ----------------
  tag_t          t3;
  logic [7:0]    d3_frac;
  logic          d3_vld;
  logic [7:0]    frac_f;
  logic          s1_vld_q, en2;
  logic [31:0]   s1_word_q, s1_word_d;
  logic [19:0]   s1_a_q;
  logic [15:0]   s1_y_q;
  logic [DV-1:0] s1_si_q;
  logic          s1_cmd_q;
  logic [1:0]    s1_st_q;
  logic [NW-1:0] s1_n_q;

  assign t3 = c4_tag_q;
  assign d3_vld = c4_vld_q;
  assign d3_frac = c4_p_q[fds_pkg::RECIP_SHIFT +: 8];
  assign en1 = !s1_vld_q || en2;

  always_comb begin
    frac_f = t3.frac;
    if (t3.cmd == fds_pkg::CMD_BUILD && t3.st == fds_pkg::ST_OK) begin
      frac_f = d3_frac;
    end
    s1_word_d = '0;
    if (t3.cmd == fds_pkg::CMD_BUILD &&
        (t3.st == fds_pkg::ST_OK || t3.st == fds_pkg::ST_SAT)) begin
      s1_word_d = {3'd0, 1'b1, 3'd0, t3.sel, t3.integ, fds_pkg::FILL_BITS, frac_f};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (en1) begin
      s1_vld_q <= d3_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_word_q <= s1_word_d;
      s1_a_q    <= 20'(frac_f) * 20'(fds_pkg::FRAC_WHOLE);
      s1_y_q    <= 16'(frac_f) * 16'(fds_pkg::FRAC_PART);
      s1_si_q   <= (DV'(t3.sel) * DV'(fds_pkg::SCALE))
                 + (DV'(t3.integ) * DV'({fds_pkg::SCALE, 1'b0}));
      s1_cmd_q  <= t3.cmd;
      s1_st_q   <= (t3.cmd == fds_pkg::CMD_BUILD) ? t3.st : fds_pkg::ST_OK;
      s1_n_q    <= t3.n;
    end
  end

  // ---------------- divisor sum ----------------
  logic [16:0]   y_sum;
  logic [DV-1:0] div_d;
  logic          s2_vld_q, d4_ready;
  logic [DV-1:0] s2_div_q;
  tag2_t         s2_tag_q;
  logic [NW-1:0] s2_n_q;

  // floor(y/255) for y below 2^16
  assign y_sum = 17'(s1_y_q) + 17'(s1_y_q[15:8]) + 17'd1;
  assign div_d = DV'(s1_a_q) + DV'(y_sum[16:8]) + s1_si_q;
  assign en2 = !s2_vld_q || d4_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (en2) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      s2_div_q      <= div_d;
      s2_tag_q.cmd  <= s1_cmd_q;
      s2_tag_q.st   <= s1_st_q;
      s2_tag_q.zero <= (div_d == '0);
      s2_tag_q.word <= s1_word_q;
      s2_n_q        <= s1_n_q;
    end
  end

  // ---------------- rate parent*1e6/divisor ----------------
  logic           d4_vld, eno;
  logic [NW-1:0]  d4_quo;
  logic [DV-1:0]  d4_rem;
  logic [TW2-1:0] d4_tag;

  fds_divider #(.DW(NW), .VW(DV), .TW(TW2)) u_div_rate (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s2_vld_q),
    .in_ready_o (d4_ready),
    .dvd_i      (s2_n_q),
    .dvs_i      (s2_div_q),
    .tag_i      (TW2'(s2_tag_q)),
    .out_valid_o(d4_vld),
    .out_ready_i(eno),
    .quo_o      (d4_quo),
    .rem_o      (d4_rem),
    .tag_o      (d4_tag)
  );

  // ---------------- result register ----------------
  tag2_t         t4;
  logic [RB-1:0] rate_sat;
  fds_pkg::out_t res_d, out_q;
  logic          out_vld_q;

  assign t4 = tag2_t'(d4_tag);
  assign eno = !out_vld_q || out_ready_i;
  assign rate_sat = (d4_quo[NW-1:RB] != '0) ? {RB{1'b1}} : d4_quo[RB-1:0];

  always_comb begin
    res_d.reg_word = t4.word;
    res_d.rate_out = 32'(rate_sat);
    res_d.status   = t4.st;
    if (t4.st == fds_pkg::ST_HIGH || t4.st == fds_pkg::ST_ZERO) begin
      res_d.reg_word = '0;
      res_d.rate_out = '0;
    end else if (t4.zero) begin
      res_d.rate_out = '0;
      res_d.status   = fds_pkg::ST_ZERO;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (eno) begin
      out_vld_q <= d4_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (eno) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

### bench/fractional_divider_setting_tb.sv
module fractional_divider_setting_tb;

  localparam int unsigned LATENCY = 2 * 32 + 50;
  localparam int unsigned N_RANDOM = 1700;
  localparam longint unsigned CYCLE_LIMIT = 400000;
  localparam longint unsigned MILLION = 64'd1000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [31:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  fds_pkg::in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  fds_pkg::out_t out_data_o;

  fractional_divider_setting DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i), .cfg_data_i(cfg_data_i),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o)
  );

  always #4 clk_i = ~clk_i;

  fds_pkg::in_t pending_beats[$];
  fds_pkg::out_t expected_settings[$];
  logic [31:0] parent_hz = fds_pkg::PARENT_RESET;
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned builds_sent = 0;
  int unsigned evals_sent = 0;
  longint unsigned cycle_count = 0;
  bit quiet_tail = 1'b0;
  bit hold_send = 1'b0;
  bit in_ready_o_seen = 1'b0;
  int unsigned send_gap = 0;
  int unsigned recv_gap = 0;

  // rate that a divider word yields from the parent clock; zero_div flags a zero divisor
  function automatic logic [31:0] word_rate(input logic [31:0] word, input logic [31:0] parent,
                                            output bit zero_div);
    longint unsigned sel, integ, frac, divisor, rate;
    sel = 64'(word[fds_pkg::SEL_SHIFT]);
    integ = 64'(word[fds_pkg::INTEG_SHIFT +: 8]);
    frac = 64'(word[7:0]);
    divisor = (frac * MILLION) / 255 + sel * MILLION + 2 * integ * MILLION;
    zero_div = (divisor == 0);
    if (zero_div) return '0;
    rate = (64'(parent) * MILLION) / divisor;
    if (rate > 64'hffff_ffff) rate = 64'hffff_ffff;
    return rate[31:0];
  endfunction

  // expected divider setting for one beat
  function automatic fds_pkg::out_t divider_setting(input fds_pkg::in_t beat,
                                                    input logic [31:0] parent);
    fds_pkg::out_t r;
    bit zd;
    longint unsigned q, whole, rem, sel, integ, frac, tgt;
    r = '0;
    r.status = fds_pkg::ST_OK;
    tgt = 64'(beat.target_rate);
    if (beat.command == fds_pkg::CMD_EVAL) begin
      r.rate_out = word_rate(beat.reg_value, parent, zd);
      if (zd) r.status = fds_pkg::ST_ZERO;
    end else if (tgt == 0) begin
      r.status = fds_pkg::ST_ZERO;
    end else if (tgt * 2 > 64'(parent)) begin
      r.status = fds_pkg::ST_HIGH;
    end else begin
      q = (64'(parent) * MILLION) / tgt;
      whole = q / MILLION;
      rem = q % MILLION;
      sel = whole & 1;
      integ = whole >> 1;
      frac = (rem * 255) / MILLION;
      if (integ > 255) begin
        integ = 255;
        sel = 1;
        frac = 255;
        r.status = fds_pkg::ST_SAT;
      end
      r.reg_word = 32'(64'h1000_0000 | (sel << fds_pkg::SEL_SHIFT)
                       | (integ << fds_pkg::INTEG_SHIFT)
                       | 64'({16'd0, fds_pkg::FILL_BITS, 8'd0}) | frac);
      r.rate_out = word_rate(r.reg_word, parent, zd);
      if (zd) r.status = fds_pkg::ST_ZERO;
    end
    return r;
  endfunction

  function automatic fds_pkg::in_t build_beat(input logic [31:0] tgt);
    fds_pkg::in_t b;
    b.command = fds_pkg::CMD_BUILD;
    b.target_rate = tgt;
    b.reg_value = $urandom;
    return b;
  endfunction

  function automatic fds_pkg::in_t eval_beat(input logic [31:0] word);
    fds_pkg::in_t b;
    b.command = fds_pkg::CMD_EVAL;
    b.target_rate = $urandom;
    b.reg_value = word;
    return b;
  endfunction

  // mostly reachable targets, spread over the divide ratio range, some noise
  function automatic fds_pkg::in_t random_beat(input logic [31:0] parent);
    logic [31:0] half;
    longint unsigned ratio;
    half = parent >> 1;
    case ($urandom_range(9))
      0, 1, 2, 3: begin
        ratio = 64'($urandom_range(2000, 2 * 1000 + 600000));
        return build_beat(32'((64'(parent) * 1000) / ratio));
      end
      4: return build_beat((half == 0) ? 32'd1 : $urandom_range(half, 1));
      5: return build_beat($urandom);
      6: return build_beat($urandom_range(3, 0));
      7: return eval_beat($urandom);
      default: return eval_beat({4'($urandom_range(15)), 3'd0, 1'($urandom), 8'($urandom),
                                 8'hff, 8'($urandom)});
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h expected %h (result %0d)", what, got, want, results_seen);
    mismatches++;
  endtask

  task automatic drain_and_settle();
    while (pending_beats.size() != 0 || in_valid_i || expected_settings.size() != 0)
      @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  task automatic write_parent(input logic [31:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    parent_hz = value;
  endtask

  // driver: one beat from the pending queue, with random gaps
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_ready_o_seen) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_beats.size() != 0 && !hold_send) begin
          in_data_i <= pending_beats.pop_front();
          in_valid_i <= 1'b1;
          if (!quiet_tail && $urandom_range(4) == 0) send_gap = $urandom_range(3, 1);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      if (recv_gap != 0) begin
        recv_gap--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if (!quiet_tail && $urandom_range(4) == 0) recv_gap = $urandom_range(3, 1);
      end
    end
  end

  // input acceptance seen at the rising edge
  always @(posedge clk_i) begin
    in_ready_o_seen <= 1'b0;
    if (rst_ni && in_valid_i && in_ready_o) begin
      in_ready_o_seen <= 1'b1;
      expected_settings.push_back(divider_setting(in_data_i, parent_hz));
      if (in_data_i.command == fds_pkg::CMD_EVAL) evals_sent++;
      else builds_sent++;
    end
  end

  // monitor: compare each result beat with the oldest expectation
  always @(posedge clk_i) begin
    fds_pkg::out_t want;
    cycle_count++;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (expected_settings.size() == 0) begin
        report_mismatch("unexpected beat rate_out", out_data_o.rate_out, 32'd0);
      end else begin
        want = expected_settings.pop_front();
        if (out_data_o.reg_word !== want.reg_word)
          report_mismatch("reg_word", out_data_o.reg_word, want.reg_word);
        if (out_data_o.rate_out !== want.rate_out)
          report_mismatch("rate_out", out_data_o.rate_out, want.rate_out);
        if (out_data_o.status !== want.status)
          report_mismatch("status", 32'(out_data_o.status), 32'(want.status));
      end
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("fractional_divider_setting test failed");
      $finish;
    end
  end

  // stimulus and phases
  initial begin
    logic [31:0] parents[5];
    parents = '{32'd24576000, 32'hffff_ffff, 32'd1, 32'd48000000, 32'd11289600};
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: zero, edges of half parent, saturation, all fields extreme
    pending_beats.push_back(build_beat(32'd0));
    pending_beats.push_back(build_beat(fds_pkg::PARENT_RESET >> 1));
    pending_beats.push_back(build_beat((fds_pkg::PARENT_RESET >> 1) + 32'd1));
    pending_beats.push_back(build_beat(32'hffff_ffff));
    pending_beats.push_back(build_beat(32'd1));
    pending_beats.push_back(build_beat(32'd48000));
    pending_beats.push_back(build_beat(32'd44100));
    pending_beats.push_back(build_beat(32'd3000000));
    pending_beats.push_back(build_beat(32'd96000));
    pending_beats.push_back(eval_beat(32'd0));
    pending_beats.push_back(eval_beat(32'hffff_ffff));
    pending_beats.push_back(eval_beat(32'hfe00_ff00));
    pending_beats.push_back(eval_beat(32'h0000_0001));
    pending_beats.push_back(eval_beat(32'h0100_0000));
    pending_beats.push_back(eval_beat(32'h1001_ff80));
    pending_beats.push_back(eval_beat(32'h11ff_ffff));
    drain_and_settle();

    // sender pauses until every result is back
    hold_send = 1'b1;
    repeat (20) pending_beats.push_back(random_beat(parent_hz));
    hold_send = 1'b0;
    repeat (3) @(posedge clk_i);
    hold_send = 1'b1;
    while (expected_settings.size() != 0 || in_valid_i) @(posedge clk_i);
    hold_send = 1'b0;
    drain_and_settle();

    // random phases over several parent clocks
    foreach (parents[p]) begin
      write_parent(parents[p]);
      if (p == 4) quiet_tail = 1'b1;
      repeat (N_RANDOM / 5) pending_beats.push_back(random_beat(parent_hz));
      pending_beats.push_back(build_beat(parent_hz >> 1));
      pending_beats.push_back(build_beat(32'd1));
      drain_and_settle();
    end
    write_parent($urandom);
    repeat (40) pending_beats.push_back(random_beat(parent_hz));
    drain_and_settle();

    $display("covered %0d build and %0d evaluate beats over %0d parent clock settings",
             builds_sent, evals_sent, 7);
    $display("%0d result beats checked", results_seen);
    if (mismatches == 0 && expected_settings.size() == 0) begin
      $display("fractional_divider_setting test passed");
    end else begin
      $display("fractional_divider_setting test failed");
    end
    $finish;
  end

endmodule
